/* hdl/tmsa_pkg.sv */
package tmsa_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int COUNT_BITS  = 8;
   localparam int MAX_BATCH   = 255;
   localparam int MIN_BATCH   = 3;
   localparam int DROPPED     = 2;
   localparam int COUNT_RESET = 8;

   // Wide enough for MAX_BATCH full-scale samples, so the sum never wraps.
   localparam int SUM_BITS  = $clog2(MAX_BATCH * ((1 << SAMPLE_BITS) - 1) + 1);
   localparam int DIV_STEPS = SUM_BITS;
   localparam int STEP_BITS = $clog2(DIV_STEPS);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

   typedef struct packed {
      logic [SUM_BITS-1:0]   trimmed;
      logic [COUNT_BITS-1:0] divisor;
   } tmsa_entry_type;

   typedef struct packed {
      logic           valid;
      tmsa_entry_type entry;
   } tmsa_xfer_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } tmsa_div_state_type;

endpackage

/* hdl/tmsa_front.sv */
module tmsa_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [tmsa_pkg::COUNT_BITS-1:0]      csr_data,
   input  logic                                 req_valid,
   input  logic [tmsa_pkg::SAMPLE_BITS-1:0]     req_sample,
   input  logic                                 queue_full,
   output logic                                 req_stall,
   output tmsa_pkg::tmsa_xfer_type              push
);

   logic [tmsa_pkg::COUNT_BITS-1:0]  count_ff, count_in;
   logic [tmsa_pkg::SUM_BITS-1:0]    sum_ff, sum_in;
   logic [tmsa_pkg::SAMPLE_BITS-1:0] min_ff, min_in;
   logic [tmsa_pkg::SAMPLE_BITS-1:0] max_ff, max_in;
   logic [tmsa_pkg::COUNT_BITS-1:0]  taken_ff, taken_in;

   logic [tmsa_pkg::SUM_BITS-1:0]    sum_next;
   logic [tmsa_pkg::SAMPLE_BITS-1:0] min_next;
   logic [tmsa_pkg::SAMPLE_BITS-1:0] max_next;
   logic [tmsa_pkg::COUNT_BITS-1:0]  taken_next;
   logic                             accept;
   logic                             close;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      sum_next   = sum_ff + tmsa_pkg::SUM_BITS'(req_sample);
      min_next   = (req_sample < min_ff) ? req_sample : min_ff;
      max_next   = (req_sample > max_ff) ? req_sample : max_ff;
      taken_next = taken_ff + tmsa_pkg::COUNT_BITS'(1);
      // A batch closes once the tally reaches or passes the current count,
      // which covers a count lowered partway through a batch.
      close      = taken_next >= count_ff;
   end

   always_comb begin
      push.valid         = accept && close;
      push.entry.trimmed = sum_next - tmsa_pkg::SUM_BITS'(min_next)
                           - tmsa_pkg::SUM_BITS'(max_next);
      push.entry.divisor = count_ff - tmsa_pkg::COUNT_BITS'(tmsa_pkg::DROPPED);
   end

   always_comb begin
      count_in = count_ff;
      if (csr_write) begin
         if (csr_data < tmsa_pkg::COUNT_BITS'(tmsa_pkg::MIN_BATCH)) begin
            count_in = tmsa_pkg::COUNT_BITS'(tmsa_pkg::MIN_BATCH);
         end else if (csr_data > tmsa_pkg::COUNT_BITS'(tmsa_pkg::MAX_BATCH)) begin
            count_in = tmsa_pkg::COUNT_BITS'(tmsa_pkg::MAX_BATCH);
         end else begin
            count_in = csr_data;
         end
      end
   end

   always_comb begin
      sum_in   = sum_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      taken_in = taken_ff;
      if (accept) begin
         if (close) begin
            sum_in   = '0;
            min_in   = tmsa_pkg::SAMPLE_MAX;
            max_in   = '0;
            taken_in = '0;
         end else begin
            sum_in   = sum_next;
            min_in   = min_next;
            max_in   = max_next;
            taken_in = taken_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= tmsa_pkg::COUNT_BITS'(tmsa_pkg::COUNT_RESET);
         sum_ff   <= '0;
         min_ff   <= tmsa_pkg::SAMPLE_MAX;
         max_ff   <= '0;
         taken_ff <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         taken_ff <= taken_in;
      end
   end

endmodule

/* hdl/tmsa_queue.sv */
module tmsa_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  tmsa_pkg::tmsa_xfer_type       push,
   input  logic                          pop,
   output logic                          full,
   output tmsa_pkg::tmsa_xfer_type       head
);

   tmsa_pkg::tmsa_entry_type           entries_ff [tmsa_pkg::QUEUE_DEPTH];
   logic [tmsa_pkg::QPTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [tmsa_pkg::QPTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [tmsa_pkg::QCNT_BITS-1:0]     fill_ff, fill_in;

   assign full       = fill_ff == tmsa_pkg::QCNT_BITS'(tmsa_pkg::QUEUE_DEPTH);
   assign head.valid = fill_ff != '0;
   assign head.entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == tmsa_pkg::QPTR_BITS'(tmsa_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + tmsa_pkg::QPTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == tmsa_pkg::QPTR_BITS'(tmsa_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + tmsa_pkg::QPTR_BITS'(1);
      end
      if (push.valid && !pop) begin
         fill_in = fill_ff + tmsa_pkg::QCNT_BITS'(1);
      end else if (pop && !push.valid) begin
         fill_in = fill_ff - tmsa_pkg::QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue read while empty");

endmodule

/* hdl/tmsa_divider.sv */
module tmsa_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  tmsa_pkg::tmsa_xfer_type           head,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tmsa_pkg::SAMPLE_BITS-1:0]  rsp_average
);

   tmsa_pkg::tmsa_div_state_type       state_ff, state_in;
   logic [tmsa_pkg::SUM_BITS-1:0]      work_ff, work_in;
   logic [tmsa_pkg::COUNT_BITS-1:0]    rem_ff, rem_in;
   logic [tmsa_pkg::COUNT_BITS-1:0]    div_ff, div_in;
   logic [tmsa_pkg::STEP_BITS-1:0]     step_ff, step_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [tmsa_pkg::SAMPLE_BITS-1:0]   rsp_average_ff, rsp_average_in;

   logic                               last_step;
   logic                               out_free;
   logic                               load_out;
   logic [tmsa_pkg::COUNT_BITS:0]      shifted;
   logic [tmsa_pkg::COUNT_BITS:0]      diff;
   logic                               fits;
   logic [tmsa_pkg::SAMPLE_BITS-1:0]   quotient_sat;

   assign last_step = step_ff == tmsa_pkg::STEP_BITS'(tmsa_pkg::DIV_STEPS - 1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tmsa_pkg::DIV_IDLE: begin
            if (head.valid) begin
               state_in = tmsa_pkg::DIV_RUN;
            end
         end
         tmsa_pkg::DIV_RUN: begin
            if (last_step) begin
               state_in = tmsa_pkg::DIV_DONE;
            end
         end
         tmsa_pkg::DIV_DONE: begin
            if (out_free) begin
               state_in = tmsa_pkg::DIV_IDLE;
            end
         end
         default: begin
            state_in = tmsa_pkg::DIV_IDLE;
         end
      endcase
   end

   always_comb begin
      pop      = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         tmsa_pkg::DIV_IDLE: pop      = head.valid;
         tmsa_pkg::DIV_DONE: load_out = out_free;
         default: begin
            pop      = 1'b0;
            load_out = 1'b0;
         end
      endcase
   end

   // Restoring division: the quotient bits shift in at the bottom of the
   // work register as the dividend bits leave at the top.
   always_comb begin
      shifted = {rem_ff, work_ff[tmsa_pkg::SUM_BITS-1]};
      diff    = shifted - {1'b0, div_ff};
      fits    = shifted >= {1'b0, div_ff};
   end

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      if (pop) begin
         work_in = head.entry.trimmed;
         rem_in  = '0;
         div_in  = head.entry.divisor;
         step_in = '0;
      end else if (state_ff == tmsa_pkg::DIV_RUN) begin
         work_in = {work_ff[tmsa_pkg::SUM_BITS-2:0], fits};
         rem_in  = fits ? diff[tmsa_pkg::COUNT_BITS-1:0]
                        : shifted[tmsa_pkg::COUNT_BITS-1:0];
         step_in = step_ff + tmsa_pkg::STEP_BITS'(1);
      end
   end

   // Only a count lowered mid-batch can push the quotient past full scale.
   always_comb begin
      if (|work_ff[tmsa_pkg::SUM_BITS-1:tmsa_pkg::SAMPLE_BITS]) begin
         quotient_sat = tmsa_pkg::SAMPLE_MAX;
      end else begin
         quotient_sat = work_ff[tmsa_pkg::SAMPLE_BITS-1:0];
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_average_in = rsp_average_ff;
      if (load_out) begin
         rsp_valid_in   = 1'b1;
         rsp_average_in = quotient_sat;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmsa_pkg::DIV_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff        <= work_in;
      rem_ff         <= rem_in;
      div_ff         <= div_in;
      rsp_average_ff <= rsp_average_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;

   a_pop_starts_run: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == tmsa_pkg::DIV_RUN) && (step_ff == '0))
      else $error("division did not start after queue read");

   a_run_ends_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tmsa_pkg::DIV_RUN) && last_step |=> state_ff == tmsa_pkg::DIV_DONE)
      else $error("division did not finish after the last step");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == tmsa_pkg::DIV_DONE)
      else $error("result raised outside of the finishing state");

endmodule

/* hdl/trimmed_mean_sample_averager_top.sv */
// The closing sample writes its batch into the queue; the idle divider pops it,
// divides it bit by bit in DIV_RUN and registers the result from DIV_DONE.
// Throughput: one sample per cycle; the divider takes one batch at a time.
// A two-entry queue stalls samples only when it is full. Reset is synchronous
// and active high: the batch clears, the queue and output empty, and the sample
// count returns to 8.
module trimmed_mean_sample_averager_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [tmsa_pkg::COUNT_BITS-1:0]      csr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [tmsa_pkg::SAMPLE_BITS-1:0]     req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tmsa_pkg::SAMPLE_BITS-1:0]     rsp_average
);

   tmsa_pkg::tmsa_xfer_type push;
   tmsa_pkg::tmsa_xfer_type head;
   logic                    queue_full;
   logic                    pop;

   tmsa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_data   (csr_data),
      .req_valid  (req_valid),
      .req_sample (req_sample),
      .queue_full (queue_full),
      .req_stall  (req_stall),
      .push       (push)
   );

   tmsa_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   tmsa_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_average (rsp_average)
   );

endmodule

/* bench/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_ITEMS   = 90;

   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             csr_write   = 1'b0;
   logic [tmsa_pkg::COUNT_BITS-1:0]  csr_data    = '0;
   logic                             req_valid   = 1'b0;
   logic                             req_stall;
   logic [tmsa_pkg::SAMPLE_BITS-1:0] req_sample  = '0;
   logic                             rsp_valid;
   logic                             rsp_stall   = 1'b0;
   logic [tmsa_pkg::SAMPLE_BITS-1:0] rsp_average;

   // Shadow of the batch accumulator, updated on every accepted transaction.
   logic [tmsa_pkg::COUNT_BITS-1:0]  batch_size =
      tmsa_pkg::COUNT_BITS'(tmsa_pkg::COUNT_RESET);
   int unsigned                      batch_sum  = 0;
   logic [tmsa_pkg::SAMPLE_BITS-1:0] batch_low  = tmsa_pkg::SAMPLE_MAX;
   logic [tmsa_pkg::SAMPLE_BITS-1:0] batch_high = '0;
   logic [tmsa_pkg::COUNT_BITS-1:0]  batch_fill = '0;

   logic [tmsa_pkg::SAMPLE_BITS-1:0] expected_averages[$];

   int sender_idle_pct   = 0;
   int receiver_stall_pct = 0;
   int mismatches        = 0;
   int quiet_cycles      = 0;

   trimmed_mean_sample_averager_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_average (rsp_average)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t ns: MISMATCH %s", $time, what);
   endtask

   task automatic clear_batch();
      batch_sum  = 0;
      batch_low  = tmsa_pkg::SAMPLE_MAX;
      batch_high = '0;
      batch_fill = '0;
   endtask

   task automatic absorb_sample(input logic [tmsa_pkg::SAMPLE_BITS-1:0] s);
      int unsigned trimmed;
      int unsigned quotient;
      batch_sum += s;
      if (s < batch_low) batch_low = s;
      if (s > batch_high) batch_high = s;
      batch_fill = batch_fill + 1'b1;
      // A count lowered mid-batch closes the batch as soon as the fill passes it.
      if (batch_fill >= batch_size) begin
         trimmed  = batch_sum - batch_low - batch_high;
         quotient = trimmed / (batch_size - tmsa_pkg::DROPPED);
         if (quotient > tmsa_pkg::SAMPLE_MAX) quotient = tmsa_pkg::SAMPLE_MAX;
         expected_averages.push_back(quotient[tmsa_pkg::SAMPLE_BITS-1:0]);
         clear_batch();
      end
   endtask

   // Entered and left at a falling edge.
   task automatic push_sample(input logic [tmsa_pkg::SAMPLE_BITS-1:0] s);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid  <= 1'b0;
         req_sample <= tmsa_pkg::SAMPLE_BITS'($urandom);
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      absorb_sample(s);
      @(negedge clock);
   endtask

   task automatic write_sample_count(input logic [tmsa_pkg::COUNT_BITS-1:0] value);
      req_valid <= 1'b0;
      csr_write <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      if (value < tmsa_pkg::MIN_BATCH) begin
         batch_size = tmsa_pkg::COUNT_BITS'(tmsa_pkg::MIN_BATCH);
      end else if (value > tmsa_pkg::MAX_BATCH) begin
         batch_size = tmsa_pkg::COUNT_BITS'(tmsa_pkg::MAX_BATCH);
      end else begin
         batch_size = value;
      end
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Waits until every expected result has been taken, then lets the block
   // settle before the count may change.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (expected_averages.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [tmsa_pkg::SAMPLE_BITS-1:0] pick_sample();
      int r;
      r = $urandom_range(99);
      if (r < 10) return '0;
      if (r < 20) return tmsa_pkg::SAMPLE_MAX;
      if (r < 30) begin
         return tmsa_pkg::SAMPLE_MAX - tmsa_pkg::SAMPLE_BITS'($urandom_range(3));
      end
      return tmsa_pkg::SAMPLE_BITS'($urandom);
   endfunction

   function automatic logic [tmsa_pkg::COUNT_BITS-1:0] pick_count();
      int r;
      r = $urandom_range(99);
      if (r < 6) return tmsa_pkg::COUNT_BITS'($urandom_range(0, tmsa_pkg::DROPPED));
      if (r < 12) return tmsa_pkg::COUNT_BITS'(tmsa_pkg::MAX_BATCH);
      if (r < 22) return tmsa_pkg::COUNT_BITS'(tmsa_pkg::MIN_BATCH);
      if (r < 30) return tmsa_pkg::COUNT_BITS'($urandom);
      return tmsa_pkg::COUNT_BITS'($urandom_range(tmsa_pkg::MIN_BATCH, 16));
   endfunction

   task automatic test_default_batch();
      logic [tmsa_pkg::SAMPLE_BITS-1:0] values[8];
      values = '{12'd0, 12'hfff, 12'd1, 12'd2048, 12'hffe, 12'd7, 12'd100, 12'hfff};
      foreach (values[i]) push_sample(values[i]);
      wait_until_idle();
   endtask

   task automatic test_count_clamp();
      write_sample_count(8'd0);
      repeat (3) push_sample(tmsa_pkg::SAMPLE_MAX);
      wait_until_idle();
      write_sample_count(8'd2);
      repeat (3) push_sample('0);
      wait_until_idle();
   endtask

   // Lowering the count under a full-scale partial batch forces saturation.
   task automatic test_count_lowered_mid_batch();
      write_sample_count(8'd10);
      repeat (8) push_sample(tmsa_pkg::SAMPLE_MAX);
      wait_until_idle();
      write_sample_count(tmsa_pkg::COUNT_BITS'(tmsa_pkg::MIN_BATCH));
      push_sample(tmsa_pkg::SAMPLE_MAX);
      wait_until_idle();
   endtask

   task automatic test_random_batches(input int sender_pct, input int stall_pct);
      int sent;
      int burst;
      sent = 0;
      sender_idle_pct    = sender_pct;
      receiver_stall_pct = stall_pct;
      while (sent < RANDOM_ITEMS) begin
         write_sample_count(pick_count());
         if (batch_size >= 64) burst = batch_size + $urandom_range(8);
         else burst = $urandom_range(10, 60);
         repeat (burst) push_sample(pick_sample());
         sent += burst;
         // Leaves the batch partly filled at times, so the next write lands mid-batch.
         wait_until_idle();
      end
   endtask

   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_averages.size() == 0) begin
            report_mismatch($sformatf("average %0d with no batch closed", rsp_average));
         end else begin
            if (rsp_average !== expected_averages[0])
               report_mismatch($sformatf("average %0d, expected %0d",
                                         rsp_average, expected_averages[0]));
            void'(expected_averages.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("trimmed_mean_sample_averager_top test failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_default_batch();
      test_count_clamp();
      test_count_lowered_mid_batch();
      test_random_batches(0, 0);
      test_random_batches(65, 0);
      test_random_batches(0, 65);
      test_random_batches(13, 13);
      receiver_stall_pct = 0;
      wait_until_idle();
      if (mismatches == 0) begin
         $display("trimmed_mean_sample_averager_top test passed");
      end else begin
         $display("trimmed_mean_sample_averager_top test failed");
      end
      $finish;
   end

endmodule
